/* sv/osc52_base64_framer_defines.svh */
// ----------------------------------------------------------------------------
// osc52_base64_framer_defines
// assertion macros for the framer's top-level rtl
// ----------------------------------------------------------------------------
`ifndef OSC52_BASE64_FRAMER_DEFINES_SVH
`define OSC52_BASE64_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define O52B64_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define O52B64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/o52b64_pkg.sv */
// ----------------------------------------------------------------------------
// o52b64_pkg
// types, character constants and lookup functions of the osc 52 framer
// ----------------------------------------------------------------------------
package o52b64_pkg;

	localparam int CMDQ_DEPTH = 4;
	localparam int INTRO_LEN  = 7;

	localparam logic [6:0] CH_BEL = 7'h07;
	localparam logic [6:0] CH_PAD = 7'h3D;

	// one unit of work for the back end
	typedef struct packed {
		logic        intro;
		logic [2:0]  ndata;
		logic [1:0]  npad;
		logic        bel;
		logic [23:0] group;
	} cmd_t;

	// emitter sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INTRO = 5'b00010,
		ST_DATA  = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_BEL   = 5'b10000
	} bk_state_t;

	// base64 alphabet: A-Z a-z 0-9 + /
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26)
			return w + 7'd65;
		else if (v < 6'd52)
			return w + 7'd71;
		else if (v < 6'd62)
			return w - 7'd4;
		else if (v == 6'd62)
			return 7'h2B;
		else
			return 7'h2F;
	endfunction

	// introducer ESC ] 5 2 ; c ;
	function automatic logic [6:0] intro_char(input logic [2:0] idx);
		logic [6:0] c;
		case (idx)
			3'd0:    c = 7'h1B;
			3'd1:    c = 7'h5D;
			3'd2:    c = 7'h35;
			3'd3:    c = 7'h32;
			3'd5:    c = 7'h63;
			default: c = 7'h3B;
		endcase
		return c;
	endfunction

endpackage

/* sv/o52b64_front.sv */
// ----------------------------------------------------------------------------
// o52b64_front
// accepts bytes, tracks the partial base64 group and issues work commands
// ----------------------------------------------------------------------------
module o52b64_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          data_byte,
	input  logic                has_byte,
	input  logic                is_last,
	input  logic                disable_output,
	input  logic                q_full,
	output logic                q_push,
	output o52b64_pkg::cmd_t    q_entry
);

	logic        in_message_q;
	logic [1:0]  held_count_q;
	logic [15:0] held_bytes_q;

	logic        accept;
	logic        in_message_d;
	logic [1:0]  held_count_d;
	logic [15:0] held_bytes_d;
	logic [1:0]  cnt_mid;
	logic [15:0] held_mid;
	o52b64_pkg::cmd_t cmd;

	assign full   = q_full;
	assign accept = push && !q_full;

	// classify the item and work out the command
	always_comb begin
		cmd          = '0;
		cnt_mid      = held_count_q;
		held_mid     = held_bytes_q;
		in_message_d = in_message_q;
		held_count_d = held_count_q;
		held_bytes_d = held_bytes_q;

		cmd.intro = (has_byte || is_last) && !in_message_q;

		// byte joins the group, a full group goes out as four characters
		if (has_byte) begin
			if (held_count_q == 2'd2) begin
				cmd.group = {held_bytes_q, data_byte};
				cmd.ndata = 3'd4;
				cnt_mid   = 2'd0;
				held_mid  = '0;
			end else if (held_count_q == 2'd1) begin
				cnt_mid  = 2'd2;
				held_mid = {held_bytes_q[15:8], data_byte};
			end else begin
				cnt_mid  = 2'd1;
				held_mid = {data_byte, 8'h00};
			end
		end

		// end of message: flush what is held with padding, then bel
		if (is_last) begin
			cmd.bel = 1'b1;
			if (cnt_mid == 2'd1) begin
				cmd.group = {held_mid, 8'h00};
				cmd.ndata = 3'd2;
				cmd.npad  = 2'd2;
			end else if (cnt_mid == 2'd2) begin
				cmd.group = {held_mid, 8'h00};
				cmd.ndata = 3'd3;
				cmd.npad  = 2'd1;
			end
		end

		if (disable_output || is_last) begin
			in_message_d = 1'b0;
			held_count_d = 2'd0;
			held_bytes_d = '0;
		end else if (has_byte) begin
			in_message_d = 1'b1;
			held_count_d = cnt_mid;
			held_bytes_d = held_mid;
		end
	end

	assign q_entry = cmd;
	assign q_push  = accept && !disable_output
		&& (cmd.intro || (cmd.ndata != 3'd0) || cmd.bel);

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
			held_count_q <= 2'd0;
			held_bytes_q <= '0;
		end else if (accept) begin
			in_message_q <= in_message_d;
			held_count_q <= held_count_d;
			held_bytes_q <= held_bytes_d;
		end
	end

endmodule

/* sv/o52b64_cmdq.sv */
// ----------------------------------------------------------------------------
// o52b64_cmdq
// small command queue between the front and back ends
// ----------------------------------------------------------------------------
module o52b64_cmdq #(
	parameter int DEPTH = o52b64_pkg::CMDQ_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  o52b64_pkg::cmd_t wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output o52b64_pkg::cmd_t rd_data,
	output logic             q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	o52b64_pkg::cmd_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == FULL_CNT);
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr)
			entries_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* sv/o52b64_back.sv */
// ----------------------------------------------------------------------------
// o52b64_back
// steps through each command, one character a cycle while output is free
// ----------------------------------------------------------------------------
module o52b64_back (
	input  logic             clk,
	input  logic             arst_n,
	input  o52b64_pkg::cmd_t q_head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic [6:0]       out_char,
	output logic             seq_end,
	output logic             empty,
	input  logic             pop
);

	localparam logic [2:0] INTRO_LAST = 3'(o52b64_pkg::INTRO_LEN - 1);

	o52b64_pkg::bk_state_t state_q, state_d;
	o52b64_pkg::cmd_t      cmd_q;
	logic [2:0]            idx_q, idx_d;
	logic                  out_valid_q;
	logic [6:0]            out_char_q;
	logic                  seq_end_q;
	logic                  emit_ok;
	logic                  emit;
	logic [6:0]            ch;
	logic                  ch_end;
	logic [5:0]            sextet;

	function automatic o52b64_pkg::bk_state_t after_pad(input o52b64_pkg::cmd_t c);
		return c.bel ? o52b64_pkg::ST_BEL : o52b64_pkg::ST_IDLE;
	endfunction

	function automatic o52b64_pkg::bk_state_t after_data(input o52b64_pkg::cmd_t c);
		return (c.npad != 2'd0) ? o52b64_pkg::ST_PAD : after_pad(c);
	endfunction

	function automatic o52b64_pkg::bk_state_t after_intro(input o52b64_pkg::cmd_t c);
		return (c.ndata != 3'd0) ? o52b64_pkg::ST_DATA : after_data(c);
	endfunction

	// sextet picked by position within the group
	always_comb begin
		case (idx_q[1:0])
			2'd0:    sextet = cmd_q.group[23:18];
			2'd1:    sextet = cmd_q.group[17:12];
			2'd2:    sextet = cmd_q.group[11:6];
			default: sextet = cmd_q.group[5:0];
		endcase
	end

	assign emit_ok = !out_valid_q || pop;

	// sequencer
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		ch      = '0;
		ch_end  = 1'b0;
		unique case (state_q)
			o52b64_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					idx_d   = '0;
					state_d = q_head.intro ? o52b64_pkg::ST_INTRO : after_intro(q_head);
				end
			end
			o52b64_pkg::ST_INTRO: begin
				ch = o52b64_pkg::intro_char(idx_q);
				if (emit_ok) begin
					emit = 1'b1;
					if (idx_q == INTRO_LAST) begin
						idx_d   = '0;
						state_d = after_intro(cmd_q);
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			o52b64_pkg::ST_DATA: begin
				ch = o52b64_pkg::b64_char(sextet);
				if (emit_ok) begin
					emit = 1'b1;
					if (idx_q == cmd_q.ndata - 3'd1) begin
						idx_d   = '0;
						state_d = after_data(cmd_q);
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			o52b64_pkg::ST_PAD: begin
				ch = o52b64_pkg::CH_PAD;
				if (emit_ok) begin
					emit = 1'b1;
					if (idx_q == {1'b0, cmd_q.npad} - 3'd1) begin
						idx_d   = '0;
						state_d = after_pad(cmd_q);
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			o52b64_pkg::ST_BEL: begin
				ch     = o52b64_pkg::CH_BEL;
				ch_end = 1'b1;
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = o52b64_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = o52b64_pkg::ST_IDLE;
			end
		endcase
	end

	// current command
	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_head;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= o52b64_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= ch;
			seq_end_q  <= ch_end;
		end
	end

	assign empty    = !out_valid_q;
	assign out_char = out_char_q;
	assign seq_end  = seq_end_q;

endmodule

/* sv/osc52_base64_framer.sv */
// ----------------------------------------------------------------------------
// osc52_base64_framer
// wraps a byte stream in an osc 52 clipboard sequence with base64 payload
// ----------------------------------------------------------------------------
// Input side is a queue: drive an item with push while full is low. Each item
// carries data_byte (used when has_byte is set) and is_last, which closes the
// message. Results come out as a queue too: while empty is low, out_char holds
// the oldest character and pop takes it; seq_end marks the closing BEL.
// The first item of a message brings the seven-character introducer, each
// third byte brings four base64 characters, and is_last adds padding and BEL.
// Flow: a taken item writes its command into the queue, the emitter loads it
// in its idle state, then one character per cycle into the output register.
// Throughput: one character per cycle set by the single-character emitter
// while the receiver keeps up; items are accepted every cycle while the
// command queue (CMDQ_DEPTH entries) has room. Items that produce nothing do
// not enter the queue. A stalled receiver holds the output register, the
// emitter waits, the queue fills and then full rises.
// cfg_data written through cfg_valid (cfg_ready is always high) sets the
// output disable; while set, items are dropped and each clears the message state.
// Reset clears the disable, the message state, the queue and the output.
// ----------------------------------------------------------------------------
`include "osc52_base64_framer_defines.svh"

module osc52_base64_framer #(
	parameter int CMDQ_DEPTH = o52b64_pkg::CMDQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       is_last,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] out_char,
	output logic       seq_end,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic             disable_q;
	logic             cmdq_push;
	logic             cmdq_full;
	logic             cmdq_pop;
	logic             cmdq_empty;
	o52b64_pkg::cmd_t cmdq_in;
	o52b64_pkg::cmd_t cmdq_head;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			disable_q <= 1'b0;
		else if (cfg_valid && cfg_ready)
			disable_q <= cfg_data;
	end

	// front end: accept and classify
	o52b64_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.is_last        (is_last),
		.disable_output (disable_q),
		.q_full         (cmdq_full),
		.q_push         (cmdq_push),
		.q_entry        (cmdq_in)
	);

	// command queue
	o52b64_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmdq_push),
		.wr_data (cmdq_in),
		.q_full  (cmdq_full),
		.rd_en   (cmdq_pop),
		.rd_data (cmdq_head),
		.q_empty (cmdq_empty)
	);

	// back end: character emitter
	o52b64_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_head   (cmdq_head),
		.q_empty  (cmdq_empty),
		.q_pop    (cmdq_pop),
		.out_char (out_char),
		.seq_end  (seq_end),
		.empty    (empty),
		.pop      (pop)
	);

	// checks
	`O52B64_ASSERT_NOW(a_cmdq_no_overflow, cmdq_push, !cmdq_full, "command queue overflow")
	`O52B64_ASSERT_NOW(a_cmd_from_enabled_item, cmdq_push, push && !full && !disable_q, "command without enabled item")
	`O52B64_ASSERT_NOW(a_seq_end_is_bel, !empty && seq_end, out_char == o52b64_pkg::CH_BEL, "seq_end on a non-bel character")

endmodule

/* tb/sv/osc52_base64_framer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osc52_base64_framer_tb
// self-checking bench for the osc 52 base64 framer
// ----------------------------------------------------------------------------
// Items go in through the push/full queue and characters come back through
// the empty/pop queue, both with random gaps. A behavioural framer in the
// bench predicts every character of each sequence as its item is taken in,
// and a checker compares each popped character against the oldest one due.
// Directed tests cover empty and idle items, all padding cases and the
// output disable. A long random run of well-formed messages with noise,
// open-ended messages and disabled stretches follows.
// ----------------------------------------------------------------------------
module osc52_base64_framer_tb;

	localparam logic [511:0] B64_ALPHA =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic [55:0]  INTRO_SEQ = {8'h1B, "]52;c;"};
	localparam int           ITEM_TARGET = 370;
	localparam int           SETTLE_CYCLES = 20;

	// one character of the framed sequence
	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
	} frame_char_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_last;
	logic       empty;
	logic       pop;
	logic [6:0] out_char;
	logic       seq_end;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;

	// framer state as the bench sees it
	logic        out_off;
	logic        msg_open;
	logic [1:0]  held_n;
	logic [15:0] held_word;

	frame_char_t chars_due[$];
	int          bad_chars;
	int          items_sent;
	int          send_calm;

	osc52_base64_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.is_last   (is_last),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.seq_end   (seq_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [6:0] b64_symbol(input logic [5:0] v);
		return B64_ALPHA[(63 - int'(v)) * 8 +: 7];
	endfunction

	function automatic void emit_char(input logic [6:0] ch, input logic fin);
		frame_char_t c;
		c.ch  = ch;
		c.fin = fin;
		chars_due.insert(chars_due.size(), c);
	endfunction

	function automatic void clear_message();
		msg_open  = 1'b0;
		held_n    = 2'd0;
		held_word = 16'h0000;
	endfunction

	// expected characters for one accepted item
	function automatic void predict_framing(input logic [7:0] d, input logic h,
		input logic l);
		logic [23:0] grp;
		if (out_off) begin
			clear_message();
			return;
		end
		if (!h && !l)
			return;
		if (!msg_open) begin
			for (int i = 0; i < o52b64_pkg::INTRO_LEN; i++)
				emit_char(INTRO_SEQ[(o52b64_pkg::INTRO_LEN - 1 - i) * 8 +: 7], 1'b0);
			msg_open = 1'b1;
		end
		if (h) begin
			if (held_n >= 2'd2) begin
				grp = {held_word, d};
				emit_char(b64_symbol(grp[23:18]), 1'b0);
				emit_char(b64_symbol(grp[17:12]), 1'b0);
				emit_char(b64_symbol(grp[11:6]), 1'b0);
				emit_char(b64_symbol(grp[5:0]), 1'b0);
				held_n    = 2'd0;
				held_word = 16'h0000;
			end else if (held_n == 2'd1) begin
				held_word[7:0] = d;
				held_n         = 2'd2;
			end else begin
				held_word = {d, 8'h00};
				held_n    = 2'd1;
			end
		end
		if (l) begin
			grp = {held_word, 8'h00};
			if (held_n == 2'd1) begin
				emit_char(b64_symbol(grp[23:18]), 1'b0);
				emit_char(b64_symbol(grp[17:12]), 1'b0);
				emit_char(o52b64_pkg::CH_PAD, 1'b0);
				emit_char(o52b64_pkg::CH_PAD, 1'b0);
			end else if (held_n >= 2'd2) begin
				emit_char(b64_symbol(grp[23:18]), 1'b0);
				emit_char(b64_symbol(grp[17:12]), 1'b0);
				emit_char(b64_symbol(grp[11:6]), 1'b0);
				emit_char(o52b64_pkg::CH_PAD, 1'b0);
			end
			emit_char(o52b64_pkg::CH_BEL, 1'b1);
			clear_message();
		end
	endfunction

	// push one item, after a random gap
	task automatic send_item(input logic [7:0] d, input logic h, input logic l);
		int  gap;
		bit  took;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 29) == 0)
				send_calm = $urandom_range(15, 40);
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= d;
		has_byte  <= h;
		is_last   <= l;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
		if (!out_off && (h || l))
			items_sent++;
		predict_framing(d, h, l);
	endtask

	// stop sending and wait for every due character
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (chars_due.size() != 0);
	endtask

	// write the disable register once the framer is quiet
	task automatic write_disable(input logic v);
		bit took;
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		out_off = v;
	endtask

	// idle items, empty message, bare end marker
	task automatic test_empty_and_idle();
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
	endtask

	// one, two and three trailing bytes, extreme values, '+' and '/'
	task automatic test_padding();
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hFB, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hBF, 1'b1, 1'b1);
		// ignored data byte in mid message, then bare end after one held byte
		send_item(8'h4D, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h6E, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
	endtask

	// output disable: dropped items, open sequence, fresh start
	task automatic test_disable();
		send_item(8'h41, 1'b1, 1'b0);
		write_disable(1'b1);
		// no items while disabled, so the open message carries on
		write_disable(1'b0);
		send_item(8'h42, 1'b1, 1'b0);
		send_item(8'h43, 1'b1, 1'b1);
		send_item(8'h12, 1'b1, 1'b0);
		write_disable(1'b1);
		send_item(8'h80, 1'b1, 1'b1);
		send_item(8'h7F, 1'b0, 1'b0);
		send_item(8'hC3, 1'b0, 1'b1);
		send_item(8'h99, 1'b1, 1'b0);
		write_disable(1'b0);
		send_item(8'h34, 1'b1, 1'b1);
	endtask

	// random messages with noise, open ends and disabled stretches
	task automatic test_random();
		int len;
		int r;
		int fin_kind;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				write_disable(1'b1);
				repeat ($urandom_range(1, 6))
					send_item(8'($urandom), 1'($urandom), 1'($urandom));
				write_disable(1'b0);
			end else if (r < 7) begin
				wait_drained();
			end else if (r < 15) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(0, 5);
				else if (r < 95)
					len = $urandom_range(6, 20);
				else
					len = $urandom_range(30, 48);
				// ending: last on a byte, bare end marker, or left open
				fin_kind = $urandom_range(0, 99);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0)
						send_item(8'($urandom), 1'b0, 1'b0);
					send_item(8'($urandom), 1'b1, (k == len - 1) && (fin_kind < 60));
				end
				if (fin_kind < 90 && (len == 0 || fin_kind >= 60))
					send_item(8'($urandom), 1'b0, 1'b1);
			end
		end
	endtask

	// receiver: pop with random stalls
	initial begin
		int stall;
		int pop_calm;
		pop      = 1'b0;
		pop_calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (pop_calm > 0) begin
				pop_calm--;
				stall = 0;
			end else begin
				stall = pick_gap();
				if ($urandom_range(0, 29) == 0)
					pop_calm = $urandom_range(10, 30);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// checker: compare each popped character with the oldest one due
	initial begin
		frame_char_t exp_c;
		forever begin
			@(negedge clk);
			if (arst_n && pop && !empty) begin
				if (chars_due.size() == 0) begin
					$error("unexpected item: out_char=%h seq_end=%b", out_char, seq_end);
					bad_chars++;
				end else begin
					exp_c = chars_due.pop_front();
					if (out_char !== exp_c.ch) begin
						$error("out_char: expected %h, got %h", exp_c.ch, out_char);
						bad_chars++;
					end
					if (seq_end !== exp_c.fin) begin
						$error("seq_end: expected %b, got %b", exp_c.fin, seq_end);
						bad_chars++;
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

	// main sequence
	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		data_byte  = 8'h00;
		has_byte   = 1'b0;
		is_last    = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 1'b0;
		out_off    = 1'b0;
		bad_chars  = 0;
		items_sent = 0;
		send_calm  = 0;
		clear_message();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_idle();
		test_padding();
		test_disable();
		test_random();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (chars_due.size() != 0) begin
			$error("%0d characters never arrived", chars_due.size());
			bad_chars++;
		end
		if (bad_chars == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
